[rtl/dct_pkg.sv]
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants for the 8x8 forward DCT
// Block geometry, pass shifts and the front-to-back command word.
// ----------------------------------------------------------------------------
package dct_pkg;
  localparam int unsigned BLK_N      = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned FIRST_SH   = 2;
  localparam int unsigned SECOND_SH  = 9;
  localparam int unsigned QDEPTH     = 2;

  // one full block handed from front to back: which sample bank holds it
  typedef struct packed {
    logic bank;
  } blk_cmd_t;

  typedef logic signed [DATA_W-1:0] word_t;
endpackage

[rtl/dct_if.sv]
// ----------------------------------------------------------------------------
// dct_stream_if: valid/ready channel with a parameterized payload
// Used for both the sample and the coefficient streams.
// ----------------------------------------------------------------------------
interface dct_stream_if #(parameter int unsigned W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/dct_front.sv]
// ----------------------------------------------------------------------------
// dct_front: sample collector
// Writes samples into a double-banked store and posts a block command when
// a bank fills up.
// ----------------------------------------------------------------------------
module dct_front import dct_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s_valid,
  output logic                    s_ready,
  input  logic [DATA_W-1:0]       s_sample,
  input  logic                    bank_busy,
  output logic                    wr_en,
  output logic [IDX_W:0]          wr_addr,
  output logic [DATA_W-1:0]       wr_data,
  output logic                    cmd_valid,
  output blk_cmd_t                cmd
);
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             bank_r, bank_nxt;
  logic             acc;

  // hold while the bank being filled is still owned by the back end
  assign s_ready = !bank_busy;
  assign acc     = s_valid && s_ready;
  assign wr_en   = acc;
  assign wr_addr = {bank_r, cnt_r};
  assign wr_data = DATA_W'($signed(s_sample[SAMPLE_WIDTH-1:0]));
  assign cmd_valid = acc && (cnt_r == IDX_W'(BLK_N-1));
  assign cmd.bank  = bank_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    bank_nxt = bank_r;
    if (acc) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cmd_valid) bank_nxt = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      bank_r <= bank_nxt;
    end
  end
endmodule

[rtl/dct_back.sv]
// ----------------------------------------------------------------------------
// dct_back: two-pass row transform engine
// Per row: read 8 words, one butterfly row, write 8 results transposed.
// ----------------------------------------------------------------------------
module dct_back import dct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  blk_cmd_t          cmd,
  input  logic              wr_en,
  input  logic [IDX_W:0]    wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [1:0]        bank_busy,
  output logic              o_valid,
  input  logic              o_ready,
  output logic [DATA_W-1:0] o_coef,
  output logic              o_last
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CALC = 5'b00100,
    S_WR   = 5'b01000,
    S_OUT  = 5'b10000
  } st_t;

  logic [DATA_W-1:0] smem [2*BLK_N];
  logic [DATA_W-1:0] tmem [BLK_N];
  logic [DATA_W-1:0] cmem [BLK_N];

  st_t              st_r, st_nxt;
  logic             bank_r;
  logic             pass_r;
  logic [2:0]       row_r;
  logic [3:0]       k_r;
  logic [IDX_W:0]   oc_r;
  logic [DATA_W-1:0] rd_q;
  logic signed [DATA_W-1:0] x_r [8];
  logic signed [DATA_W-1:0] y_r [8];
  logic [1:0]       busy_r;
  logic             ov_r;
  logic [DATA_W-1:0] oq_r;
  logic             ol_r;

  assign bank_busy = busy_r;
  assign cmd_ready = (st_r == S_IDLE);
  assign o_valid   = ov_r;
  assign o_coef    = oq_r;
  assign o_last    = ol_r;

  always_ff @(posedge clk) begin
    if (wr_en) smem[wr_addr] <= wr_data;
  end

  // registered read of the source row element k
  always_ff @(posedge clk) begin
    if (pass_r) rd_q <= tmem[{row_r, k_r[2:0]}];
    else        rd_q <= smem[{bank_r, row_r, k_r[2:0]}];
  end

  // odd/even butterfly on one row, 2 or 4 products per output, one row per read/calc/write round
  function automatic logic [DATA_W-1:0] rnd(input logic signed [31:0] v, input logic sh);
    logic signed [31:0] t;
    begin
      t = sh ? ((v + 32'sd256) >>> SECOND_SH) : ((v + 32'sd2) >>> FIRST_SH);
      return t[DATA_W-1:0];
    end
  endfunction

  logic signed [31:0] e [4], o [4], ee0, ee1, eo0, eo1;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e[i] = 32'(x_r[i]) + 32'(x_r[7-i]);
      o[i] = 32'(x_r[i]) - 32'(x_r[7-i]);
    end
    ee0 = e[0] + e[3]; ee1 = e[1] + e[2];
    eo0 = e[0] - e[3]; eo1 = e[1] - e[2];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (cmd_valid) st_nxt = S_RD;
      S_RD:   if (k_r == 4'd8) st_nxt = S_CALC;
      S_CALC: st_nxt = S_WR;
      S_WR:   if (k_r == 4'd7) st_nxt = (pass_r && row_r == 3'd7) ? S_OUT : S_RD;
      S_OUT:  if (oc_r == 7'(BLK_N) && !ov_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; busy_r <= '0; ov_r <= 1'b0;
      pass_r <= 1'b0; row_r <= '0; k_r <= '0; oc_r <= '0; bank_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cmd_valid && cmd_ready) busy_r[cmd.bank] <= 1'b1;
      unique case (st_r)
        S_IDLE: if (cmd_valid) begin
          bank_r <= cmd.bank; pass_r <= 1'b0; row_r <= '0; k_r <= '0; oc_r <= '0;
        end
        S_RD: begin
          if (k_r != 4'd0) x_r[k_r[2:0]-3'd1] <= rd_q;
          k_r <= (k_r == 4'd8) ? 4'd0 : k_r + 4'd1;
        end
        S_CALC: begin
          y_r[0] <= rnd(64*ee0 + 64*ee1, pass_r);
          y_r[4] <= rnd(64*ee0 - 64*ee1, pass_r);
          y_r[2] <= rnd(83*eo0 + 36*eo1, pass_r);
          y_r[6] <= rnd(36*eo0 - 83*eo1, pass_r);
          y_r[1] <= rnd(89*o[0] + 75*o[1] + 50*o[2] + 18*o[3], pass_r);
          y_r[3] <= rnd(75*o[0] - 18*o[1] - 89*o[2] - 50*o[3], pass_r);
          y_r[5] <= rnd(50*o[0] - 89*o[1] + 18*o[2] + 75*o[3], pass_r);
          y_r[7] <= rnd(18*o[0] - 50*o[1] + 75*o[2] - 89*o[3], pass_r);
        end
        S_WR: begin
          if (pass_r) cmem[{k_r[2:0], row_r}] <= y_r[k_r[2:0]];
          else        tmem[{k_r[2:0], row_r}] <= y_r[k_r[2:0]];
          if (k_r == 4'd7) begin
            k_r <= '0;
            row_r <= row_r + 3'd1;
            if (row_r == 3'd7) begin
              if (!pass_r) pass_r <= 1'b1;
              else busy_r[bank_r] <= 1'b0;
            end
          end else k_r <= k_r + 4'd1;
        end
        S_OUT: begin
          if ((!ov_r || o_ready) && oc_r != 7'(BLK_N)) begin
            ov_r <= 1'b1;
            oq_r <= cmem[oc_r[IDX_W-1:0]];
            ol_r <= (oc_r == 7'(BLK_N-1));
            oc_r <= oc_r + 7'd1;
          end else if (o_ready) begin
            ov_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // the last beat is the 64th one drained
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ol_r) |-> (oc_r == 7'(BLK_N))) else $error("last out of place");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |-> pass_r) else $error("drain before second pass");
  // the sample bank is released once the second pass is written
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE && st_r != S_OUT) |-> busy_r[bank_r])
    else $error("working bank not held");
endmodule

[rtl/dct8x8_forward_2d.sv]
// ----------------------------------------------------------------------------
// dct8x8_forward_2d: 8x8 forward integer DCT, two passes
// Streams in 64 samples, streams out 64 coefficients with a last flag.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: one signed sample per beat, row-major, 64 beats a block.
//   out channel: one coefficient per beat in raster order; last marks the
//   64th beat of a block.
// Throughput: the front takes one sample per cycle while not stalled, into
//   one of two sample banks; the back engine reads each row word by word,
//   transforms it and writes it transposed, 8 rows in each of 2 passes, then
//   drains 64 beats. With two banks the next block fills while the current
//   one transforms.
// Reset: clears counters, bank ownership and the output valid; the stores
//   are not cleared, every entry is written before it is read.
// Stall: a stalled receiver holds the output register; the back engine holds,
//   and the front stops taking samples while a full block waits in the queue
//   or its fill bank is still owned by the back engine.
// ----------------------------------------------------------------------------
module dct8x8_forward_2d import dct_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  dct_stream_if.sink   in_s,
  dct_stream_if.source out_s
);
  logic              wr_en, cmd_valid, cmd_ready, qv_r;
  logic [IDX_W:0]    wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [1:0]        bank_busy;
  blk_cmd_t          cmd, q_r;
  logic              fill_bank_r;
  logic              fill_busy;

  // front stalls if its fill bank is owned by the back end or a block is queued
  always_ff @(posedge clk) begin
    if (!rst_n) fill_bank_r <= 1'b0;
    else if (cmd_valid) fill_bank_r <= !fill_bank_r;
  end
  assign fill_busy = bank_busy[fill_bank_r] || qv_r;

  dct_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk, .rst_n,
    .s_valid(in_s.valid), .s_ready(in_s.ready), .s_sample(in_s.data),
    .bank_busy(fill_busy),
    .wr_en, .wr_addr, .wr_data, .cmd_valid, .cmd
  );

  // one-entry command queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) qv_r <= 1'b0;
    else begin
      if (cmd_valid) begin qv_r <= 1'b1; q_r <= cmd; end
      else if (cmd_ready) qv_r <= 1'b0;
    end
  end

  logic [DATA_W-1:0] coef;
  logic              last;
  dct_back u_back (
    .clk, .rst_n,
    .cmd_valid(qv_r), .cmd_ready, .cmd(q_r),
    .wr_en, .wr_addr, .wr_data, .bank_busy,
    .o_valid(out_s.valid), .o_ready(out_s.ready), .o_coef(coef), .o_last(last)
  );
  assign out_s.data = {last, coef};

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> !(qv_r && !cmd_ready)) else $error("command queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !bank_busy[wr_addr[IDX_W]]) else $error("write into busy bank");
  assert property (@(posedge clk) disable iff (!rst_n)
    (qv_r && cmd_ready) |=> bank_busy[$past(q_r.bank)]) else $error("bank not claimed");
endmodule

[tb/sv/tb_dct8x8_forward_2d.sv]
// ----------------------------------------------------------------------------
// tb_dct8x8_forward_2d: self-checking bench for the 8x8 forward DCT
// Streams 8x8 residual blocks into the block and predicts each coefficient
// with an independent two-pass butterfly transform. Results are compared in
// order with their last flag. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_dct8x8_forward_2d;
  import dct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 600;

  // Predicts one block of coefficients and holds them until they come out.
  class coef_scoreboard;
    word_t          blk_samples[BLK_N];
    int unsigned    fill;
    logic [DATA_W:0] pending[$];   // {last, coefficient}
    int unsigned    mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Rounding arithmetic shift, then wrap to the word width.
    function word_t round_wrap(longint v, int unsigned sh);
      longint r;
      r = (v + (longint'(1) << (sh - 1))) >>> sh;
      return word_t'(r[DATA_W-1:0]);
    endfunction

    // Transform each row of src; coefficient k of row r lands at dst[k*8+r].
    function void row_pass(input word_t src[BLK_N], output word_t dst[BLK_N],
                           input int unsigned sh);
      longint x[8], ev[4], od[4], ee0, ee1, eo0, eo1;
      for (int r = 0; r < 8; r++) begin
        for (int k = 0; k < 8; k++) x[k] = longint'(src[r*8+k]);
        for (int k = 0; k < 4; k++) begin
          ev[k] = x[k] + x[7-k];
          od[k] = x[k] - x[7-k];
        end
        ee0 = ev[0] + ev[3];
        ee1 = ev[1] + ev[2];
        eo0 = ev[0] - ev[3];
        eo1 = ev[1] - ev[2];
        dst[0*8+r] = round_wrap(64*ee0 + 64*ee1, sh);
        dst[4*8+r] = round_wrap(64*ee0 - 64*ee1, sh);
        dst[2*8+r] = round_wrap(83*eo0 + 36*eo1, sh);
        dst[6*8+r] = round_wrap(36*eo0 - 83*eo1, sh);
        dst[1*8+r] = round_wrap(89*od[0] + 75*od[1] + 50*od[2] + 18*od[3], sh);
        dst[3*8+r] = round_wrap(75*od[0] - 18*od[1] - 89*od[2] - 50*od[3], sh);
        dst[5*8+r] = round_wrap(50*od[0] - 89*od[1] + 18*od[2] + 75*od[3], sh);
        dst[7*8+r] = round_wrap(18*od[0] - 50*od[1] + 75*od[2] - 89*od[3], sh);
      end
    endfunction

    // Note one accepted sample; a full block queues 64 coefficients.
    function void note_sample(word_t s);
      word_t mid[BLK_N], coef[BLK_N];
      blk_samples[fill] = s;
      fill++;
      if (fill == BLK_N) begin
        fill = 0;
        row_pass(blk_samples, mid, FIRST_SH);
        row_pass(mid, coef, SECOND_SH);
        for (int i = 0; i < BLK_N; i++)
          pending.push_back({(i == BLK_N - 1), coef[i]});
      end
    endfunction

    // Compare one accepted coefficient beat with the oldest prediction.
    function void check_coef(word_t coef, logic last);
      logic [DATA_W:0] exp_beat;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: coef %0d last %0b", coef, last);
        return;
      end
      exp_beat = pending.pop_front();
      if (exp_beat[DATA_W-1:0] !== coef || exp_beat[DATA_W] !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("coef mismatch: expected %0d last %0b, got %0d last %0b",
                   word_t'(exp_beat[DATA_W-1:0]), exp_beat[DATA_W], coef, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet = 1'b0;   // set for the closing stretch: no idling either side
  int unsigned cycles = 0;
  coef_scoreboard sb = new();

  dct_stream_if #(.W(DATA_W))     in_if ();
  dct_stream_if #(.W(DATA_W + 1)) out_if ();

  dct8x8_forward_2d u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if)
  );

  always #5 clk = ~clk;

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: check each accepted beat, drop ready in random bursts.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_coef(word_t'(out_if.data[DATA_W-1:0]), out_if.data[DATA_W]);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= (stall_left == 0);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run once the cycle limit is passed.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Push one sample: optional gap first, then hold valid until the beat.
  task automatic send_sample(word_t s);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= s;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s);
  endtask

  // Feed one block; kind picks the content pattern.
  task automatic send_block(int kind);
    word_t s;
    for (int i = 0; i < BLK_N; i++) begin
      case (kind)
        0: s = ((i / 8 + i % 8) % 2) ? word_t'(16'h8000) : word_t'(16'h7fff);
        1: s = word_t'(16'h8000);
        2: s = word_t'(16'h7fff);
        3: s = word_t'($urandom_range(0, 511)) - word_t'(256);
        4: s = $urandom_range(0, 1) ? word_t'(16'h8000) : word_t'(16'h7fff);
        default: s = word_t'($urandom());
      endcase
      send_sample(s);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: checkerboard of extremes (pass overflow), all min, all max.
    send_block(0);
    send_block(1);
    send_block(2);
    // Random block: small residuals, extreme mix or full-range noise.
    send_block($urandom_range(3, 5));
    quiet = 1'b1;
    send_block(5);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
